/* rtl/core/wrp_pkg.sv */
// shared types and constants for the wav riff stream parser
`timescale 1ns / 1ps
`default_nettype none

package wrp_pkg;

   // parse phase codes
   localparam logic [2:0] PH_RIFF  = 3'd0;
   localparam logic [2:0] PH_CHUNK = 3'd1;
   localparam logic [2:0] PH_FMT   = 3'd2;
   localparam logic [2:0] PH_DATA  = 3'd3;
   localparam logic [2:0] PH_PAD   = 3'd4;

   // result status codes
   localparam logic [1:0] ST_HEADER  = 2'd0;
   localparam logic [1:0] ST_AUDIO   = 2'd1;
   localparam logic [1:0] ST_ERROR   = 2'd2;
   localparam logic [1:0] ST_IGNORED = 2'd3;

   // chunk ids, first byte in the top
   localparam logic [31:0] ID_RIFF = 32'h5249_4646;
   localparam logic [31:0] ID_FMT  = 32'h666D_7420;
   localparam logic [31:0] ID_DATA = 32'h6461_7461;

   localparam logic [3:0] RIFF_HEADER_LAST  = 4'd11;
   localparam logic [3:0] CHUNK_HEADER_LAST = 4'd7;
   localparam logic [3:0] CHUNK_ID_LAST     = 4'd3;
   localparam logic [3:0] RIFF_SIZE_FIRST   = 4'd4;
   localparam logic [3:0] WAVE_FIRST        = 4'd8;
   localparam logic [4:0] FMT_CAPTURE_LEN   = 5'd16;

   typedef struct packed {
      logic [1:0]   status;
      logic [7:0]   audio_byte;
      logic         last_audio;
      logic         format_ready;
      logic [127:0] format_fields;
      logic [31:0]  data_size;
   } rsp_type;

   function automatic logic [7:0] riff_id_byte(input logic [1:0] pos);
      logic [7:0] v;
      case (pos)
         2'd0:    v = 8'h52;
         2'd1:    v = 8'h49;
         default: v = 8'h46;
      endcase
      return v;
   endfunction

   function automatic logic [7:0] wave_id_byte(input logic [1:0] pos);
      logic [7:0] v;
      case (pos)
         2'd0:    v = 8'h57;
         2'd1:    v = 8'h41;
         2'd2:    v = 8'h56;
         default: v = 8'h45;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

/* rtl/core/wav_riff_stream_parser.sv */
// top level of the wav riff stream parser
//
// channel  dir  handshake          payload
// req      in   req_valid/stall    byte_value, restart
// rsp      out  rsp_valid/stall    status, audio, format fields, data_size
//
// one word accepted per cycle while req_stall is low, one result per word
// the parse state registers update in the cycle a word is accepted
// a two entry result buffer absorbs output stalls; req_stall rises when both are full
// reset is synchronous and clears parse state and buffer valids
`timescale 1ns / 1ps
`default_nettype none

module wav_riff_stream_parser (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_byte_value,
   input  wire logic        req_restart,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_status,
   output logic [7:0]       rsp_audio_byte,
   output logic             rsp_last_audio,
   output logic             rsp_format_ready,
   output logic [15:0]      rsp_format_tag,
   output logic [15:0]      rsp_channel_count,
   output logic [31:0]      rsp_sample_rate,
   output logic [31:0]      rsp_byte_rate,
   output logic [15:0]      rsp_block_align,
   output logic [15:0]      rsp_bits_per_sample,
   output logic [31:0]      rsp_data_size
);

   logic             take;
   logic             full;
   wrp_pkg::rsp_type result;
   wrp_pkg::rsp_type out_data;

   assign req_stall = full;
   assign take      = req_valid && !full;

   wrp_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .take       (take),
      .byte_value (req_byte_value),
      .restart    (req_restart),
      .result     (result)
   );

   wrp_outbuf u_outbuf (
      .clock     (clock),
      .reset     (reset),
      .push      (take),
      .push_data (result),
      .full      (full),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (out_data)
   );

   assign rsp_status          = out_data.status;
   assign rsp_audio_byte      = out_data.audio_byte;
   assign rsp_last_audio      = out_data.last_audio;
   assign rsp_format_ready    = out_data.format_ready;
   assign rsp_format_tag      = out_data.format_fields[15:0];
   assign rsp_channel_count   = out_data.format_fields[31:16];
   assign rsp_sample_rate     = out_data.format_fields[63:32];
   assign rsp_byte_rate       = out_data.format_fields[95:64];
   assign rsp_block_align     = out_data.format_fields[111:96];
   assign rsp_bits_per_sample = out_data.format_fields[127:112];
   assign rsp_data_size       = out_data.data_size;

endmodule

`default_nettype wire

/* rtl/core/wrp_parser.sv */
// parse state registers and per-word next state and result logic
`timescale 1ns / 1ps
`default_nettype none

module wrp_parser (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             take,
   input  wire logic [7:0]       byte_value,
   input  wire logic             restart,
   output wrp_pkg::rsp_type      result
);

   logic [2:0]   phase_ff, phase_in;
   logic [3:0]   idx_ff, idx_in;
   logic [31:0]  id_ff, id_in;
   logic [31:0]  size_ff, size_in;
   logic [31:0]  rem_ff, rem_in;
   logic [4:0]   fidx_ff, fidx_in;
   logic [127:0] fields_ff, fields_in;
   logic         fvalid_ff, fvalid_in;
   logic         err_ff, err_in;

   logic [2:0]   phase_cur;
   logic [3:0]   idx_cur;
   logic [31:0]  id_cur, size_cur, rem_cur;
   logic [4:0]   fidx_cur;
   logic [127:0] fields_cur;
   logic         fvalid_cur, err_cur;
   logic         bad;
   logic         show_size;
   logic [1:0]   status;
   logic [7:0]   audio;
   logic         last;

   always_comb begin
      // restart clears everything before this word is parsed
      phase_cur  = restart ? wrp_pkg::PH_RIFF : phase_ff;
      idx_cur    = restart ? 4'd0 : idx_ff;
      id_cur     = restart ? 32'd0 : id_ff;
      size_cur   = restart ? 32'd0 : size_ff;
      rem_cur    = restart ? 32'd0 : rem_ff;
      fidx_cur   = restart ? 5'd0 : fidx_ff;
      fields_cur = restart ? 128'd0 : fields_ff;
      fvalid_cur = restart ? 1'b0 : fvalid_ff;
      err_cur    = restart ? 1'b0 : err_ff;

      phase_in  = phase_cur;
      idx_in    = idx_cur;
      id_in     = id_cur;
      size_in   = size_cur;
      rem_in    = rem_cur;
      fidx_in   = fidx_cur;
      fields_in = fields_cur;
      fvalid_in = fvalid_cur;
      err_in    = err_cur;

      status    = wrp_pkg::ST_HEADER;
      audio     = 8'd0;
      last      = 1'b0;
      show_size = 1'b0;
      bad       = 1'b0;

      if (err_cur) begin
         status = wrp_pkg::ST_IGNORED;
      end else begin
         case (phase_cur)
            wrp_pkg::PH_RIFF: begin
               if (idx_cur < wrp_pkg::RIFF_SIZE_FIRST) begin
                  bad = byte_value != wrp_pkg::riff_id_byte(idx_cur[1:0]);
               end else if (idx_cur >= wrp_pkg::WAVE_FIRST) begin
                  bad = byte_value != wrp_pkg::wave_id_byte(idx_cur[1:0]);
               end
               if (bad) begin
                  err_in = 1'b1;
                  status = wrp_pkg::ST_ERROR;
               end else if (idx_cur >= wrp_pkg::RIFF_HEADER_LAST) begin
                  phase_in = wrp_pkg::PH_CHUNK;
                  idx_in   = 4'd0;
               end else begin
                  idx_in = idx_cur + 4'd1;
               end
            end
            wrp_pkg::PH_CHUNK: begin
               idx_in = idx_cur + 4'd1;
               if (idx_cur <= wrp_pkg::CHUNK_ID_LAST) begin
                  id_in = {id_cur[23:0], byte_value};
                  if (idx_cur == wrp_pkg::CHUNK_ID_LAST) begin
                     if (id_in == wrp_pkg::ID_RIFF) begin
                        phase_in = wrp_pkg::PH_RIFF;
                        idx_in   = wrp_pkg::RIFF_SIZE_FIRST;
                     end else if (id_in != wrp_pkg::ID_FMT && id_in != wrp_pkg::ID_DATA) begin
                        err_in = 1'b1;
                        status = wrp_pkg::ST_ERROR;
                     end
                  end
               end else begin
                  size_in = {byte_value, size_cur[31:8]};
                  if (idx_cur >= wrp_pkg::CHUNK_HEADER_LAST) begin
                     idx_in = 4'd0;
                     rem_in = size_in;
                     if (id_cur == wrp_pkg::ID_FMT) begin
                        fields_in = 128'd0;
                        fidx_in   = 5'd0;
                        if (size_in == 32'd0) begin
                           fvalid_in = 1'b1;
                        end else begin
                           fvalid_in = 1'b0;
                           phase_in  = wrp_pkg::PH_FMT;
                        end
                     end else begin
                        show_size = 1'b1;
                        if (size_in != 32'd0) begin
                           phase_in = wrp_pkg::PH_DATA;
                        end
                     end
                  end
               end
            end
            wrp_pkg::PH_FMT: begin
               if (fidx_cur < wrp_pkg::FMT_CAPTURE_LEN) begin
                  fields_in[{fidx_cur[3:0], 3'b000} +: 8] =
                     fields_cur[{fidx_cur[3:0], 3'b000} +: 8] | byte_value;
                  fidx_in = fidx_cur + 5'd1;
               end
               rem_in = rem_cur - 32'd1;
               if (rem_in == 32'd0) begin
                  fvalid_in = 1'b1;
                  phase_in  = size_cur[0] ? wrp_pkg::PH_PAD : wrp_pkg::PH_CHUNK;
                  idx_in    = 4'd0;
               end
            end
            wrp_pkg::PH_DATA: begin
               status    = wrp_pkg::ST_AUDIO;
               audio     = byte_value;
               show_size = 1'b1;
               rem_in    = rem_cur - 32'd1;
               if (rem_in == 32'd0) begin
                  last     = 1'b1;
                  phase_in = size_cur[0] ? wrp_pkg::PH_PAD : wrp_pkg::PH_CHUNK;
                  idx_in   = 4'd0;
               end
            end
            default: begin
               // pad byte after an odd sized body
               phase_in = wrp_pkg::PH_CHUNK;
               idx_in   = 4'd0;
            end
         endcase
      end

      result.status        = status;
      result.audio_byte    = audio;
      result.last_audio    = last;
      result.format_ready  = fvalid_in;
      result.format_fields = fields_in;
      result.data_size     = show_size ? size_in : 32'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= wrp_pkg::PH_RIFF;
         idx_ff    <= 4'd0;
         id_ff     <= 32'd0;
         size_ff   <= 32'd0;
         rem_ff    <= 32'd0;
         fidx_ff   <= 5'd0;
         fields_ff <= 128'd0;
         fvalid_ff <= 1'b0;
         err_ff    <= 1'b0;
      end else if (take) begin
         phase_ff  <= phase_in;
         idx_ff    <= idx_in;
         id_ff     <= id_in;
         size_ff   <= size_in;
         rem_ff    <= rem_in;
         fidx_ff   <= fidx_in;
         fields_ff <= fields_in;
         fvalid_ff <= fvalid_in;
         err_ff    <= err_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/wrp_outbuf.sv */
// result register with skid stage
`timescale 1ns / 1ps
`default_nettype none

module wrp_outbuf (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire wrp_pkg::rsp_type push_data,
   output logic                  full,
   output logic                  out_valid,
   input  wire logic             out_stall,
   output wrp_pkg::rsp_type      out_data
);

   logic             main_valid_ff, main_valid_in;
   logic             skid_valid_ff, skid_valid_in;
   wrp_pkg::rsp_type main_ff, main_in;
   wrp_pkg::rsp_type skid_ff, skid_in;
   logic             main_free;

   always_comb begin
      main_free     = !main_valid_ff || !out_stall;
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (main_free) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            main_valid_in = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            main_in       = push_data;
            main_valid_in = push;
         end
      end else if (push) begin
         skid_in       = push_data;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign full      = skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

endmodule

`default_nettype wire

/* rtl/core/wrp_checker.sv */
// port level checks for the wav riff stream parser
`timescale 1ns / 1ps
`default_nettype none

module wrp_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_stall,
   input  wire logic [1:0]  rsp_status,
   input  wire logic [7:0]  rsp_audio_byte,
   input  wire logic        rsp_last_audio,
   input  wire logic [31:0] rsp_data_size
);

   // stalled word holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_audio_byte) && $stable(rsp_data_size))
      else $error("stalled result changed");

   // last mark only on audio
   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_audio |-> rsp_status == wrp_pkg::ST_AUDIO)
      else $error("last mark on non audio word");

   // audio byte zero outside audio
   a_audio: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != wrp_pkg::ST_AUDIO |-> rsp_audio_byte == 8'd0)
      else $error("audio byte set on non audio word");

   // data size shown only on header or audio words
   a_size: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data_size != 32'd0 |->
         rsp_status == wrp_pkg::ST_HEADER || rsp_status == wrp_pkg::ST_AUDIO)
      else $error("data size on error word");

   // reset empties the result buffer
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind wav_riff_stream_parser wrp_checker u_wrp_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_status     (rsp_status),
   .rsp_audio_byte (rsp_audio_byte),
   .rsp_last_audio (rsp_last_audio),
   .rsp_data_size  (rsp_data_size)
);

`default_nettype wire

/* tb/testbench.sv */
// testbench for wav riff stream parser, directed and random byte streams vs a parse predictor
`timescale 1ns / 1ps

module testbench;

   localparam int          QUIET_LIMIT = 2000;
   localparam int          HOLD_CYCLES = 64;
   localparam int          RANDOM_BYTES = 250;
   localparam logic [31:0] WAVE_TAG = 32'h5741_5645;
   localparam logic [31:0] JUNK_TAG = 32'h4A55_4E4B;

   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  audio_byte;
      logic        last_audio;
      logic        format_ready;
      logic [15:0] format_tag;
      logic [15:0] channel_count;
      logic [31:0] sample_rate;
      logic [31:0] byte_rate;
      logic [15:0] block_align;
      logic [15:0] bits_per_sample;
      logic [31:0] data_size;
   } wav_result_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_byte_value = 8'h00;
   logic        req_restart = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_status;
   logic [7:0]  rsp_audio_byte;
   logic        rsp_last_audio;
   logic        rsp_format_ready;
   logic [15:0] rsp_format_tag;
   logic [15:0] rsp_channel_count;
   logic [31:0] rsp_sample_rate;
   logic [31:0] rsp_byte_rate;
   logic [15:0] rsp_block_align;
   logic [15:0] rsp_bits_per_sample;
   logic [31:0] rsp_data_size;

   // predicted parser state
   logic [2:0]   phase;
   logic [3:0]   hdr_idx;
   logic [31:0]  id_shift;
   logic [31:0]  size_shift;
   logic [31:0]  body_left;
   logic [31:0]  fmt_count;
   logic [127:0] fmt_bytes;
   logic         fmt_done;
   logic         parse_failed;

   wav_result_type wav_results_due[$];

   logic sender_gaps = 1'b1;
   logic receiver_stalls = 1'b1;
   logic hold_receiver = 1'b0;
   int   parsed_bytes = 0;
   int   mismatches = 0;
   int   quiet_cycles = 0;

   wav_riff_stream_parser dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_byte_value      (req_byte_value),
      .req_restart         (req_restart),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_status          (rsp_status),
      .rsp_audio_byte      (rsp_audio_byte),
      .rsp_last_audio      (rsp_last_audio),
      .rsp_format_ready    (rsp_format_ready),
      .rsp_format_tag      (rsp_format_tag),
      .rsp_channel_count   (rsp_channel_count),
      .rsp_sample_rate     (rsp_sample_rate),
      .rsp_byte_rate       (rsp_byte_rate),
      .rsp_block_align     (rsp_block_align),
      .rsp_bits_per_sample (rsp_bits_per_sample),
      .rsp_data_size       (rsp_data_size)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic void clear_parse_state();
      phase = wrp_pkg::PH_RIFF;
      hdr_idx = '0;
      id_shift = '0;
      size_shift = '0;
      body_left = '0;
      fmt_count = '0;
      fmt_bytes = '0;
      fmt_done = 1'b0;
      parse_failed = 1'b0;
   endfunction

   function automatic void close_body();
      phase = size_shift[0] ? wrp_pkg::PH_PAD : wrp_pkg::PH_CHUNK;
      hdr_idx = '0;
   endfunction

   // advances the predicted parser by one byte and queues the expected result
   function automatic void parse_wav_byte(input logic [7:0] b, input logic rs);
      wav_result_type r;
      logic           bad;
      logic           show_size;
      int             i;
      if (rs)
         clear_parse_state();
      r = '0;
      bad = 1'b0;
      show_size = 1'b0;
      i = hdr_idx;
      if (parse_failed) begin
         r.status = wrp_pkg::ST_IGNORED;
      end else begin
         case (phase)
            wrp_pkg::PH_RIFF: begin
               if (hdr_idx < wrp_pkg::RIFF_SIZE_FIRST)
                  bad = b != 8'(wrp_pkg::ID_RIFF >> (8 * (3 - i)));
               else if (hdr_idx >= wrp_pkg::WAVE_FIRST)
                  bad = b != 8'(WAVE_TAG >> (8 * (11 - i)));
               if (bad) begin
                  parse_failed = 1'b1;
                  r.status = wrp_pkg::ST_ERROR;
               end else if (hdr_idx == wrp_pkg::RIFF_HEADER_LAST) begin
                  phase = wrp_pkg::PH_CHUNK;
                  hdr_idx = '0;
               end else begin
                  hdr_idx = hdr_idx + 1'b1;
               end
            end
            wrp_pkg::PH_CHUNK: begin
               if (hdr_idx <= wrp_pkg::CHUNK_ID_LAST) begin
                  id_shift = {id_shift[23:0], b};
                  hdr_idx = hdr_idx + 1'b1;
                  if (i == wrp_pkg::CHUNK_ID_LAST) begin
                     if (id_shift == wrp_pkg::ID_RIFF) begin
                        phase = wrp_pkg::PH_RIFF;
                        hdr_idx = wrp_pkg::RIFF_SIZE_FIRST;
                     end else if (id_shift != wrp_pkg::ID_FMT &&
                                  id_shift != wrp_pkg::ID_DATA) begin
                        parse_failed = 1'b1;
                        r.status = wrp_pkg::ST_ERROR;
                     end
                  end
               end else begin
                  size_shift = {b, size_shift[31:8]};
                  if (hdr_idx == wrp_pkg::CHUNK_HEADER_LAST) begin
                     hdr_idx = '0;
                     body_left = size_shift;
                     if (id_shift == wrp_pkg::ID_FMT) begin
                        fmt_bytes = '0;
                        fmt_count = '0;
                        fmt_done = size_shift == 0;
                        if (size_shift != 0)
                           phase = wrp_pkg::PH_FMT;
                     end else begin
                        show_size = 1'b1;
                        if (size_shift != 0)
                           phase = wrp_pkg::PH_DATA;
                     end
                  end else begin
                     hdr_idx = hdr_idx + 1'b1;
                  end
               end
            end
            wrp_pkg::PH_FMT: begin
               if (fmt_count < wrp_pkg::FMT_CAPTURE_LEN)
                  fmt_bytes[8 * fmt_count +: 8] = b;
               fmt_count = fmt_count + 1;
               body_left = body_left - 1;
               if (body_left == 0) begin
                  fmt_done = 1'b1;
                  close_body();
               end
            end
            wrp_pkg::PH_DATA: begin
               r.status = wrp_pkg::ST_AUDIO;
               r.audio_byte = b;
               show_size = 1'b1;
               body_left = body_left - 1;
               if (body_left == 0) begin
                  r.last_audio = 1'b1;
                  close_body();
               end
            end
            default: begin
               phase = wrp_pkg::PH_CHUNK;
               hdr_idx = '0;
            end
         endcase
      end
      r.format_ready = fmt_done;
      r.format_tag = fmt_bytes[15:0];
      r.channel_count = fmt_bytes[31:16];
      r.sample_rate = fmt_bytes[63:32];
      r.byte_rate = fmt_bytes[95:64];
      r.block_align = fmt_bytes[111:96];
      r.bits_per_sample = fmt_bytes[127:112];
      r.data_size = show_size ? size_shift : 32'h0;
      wav_results_due.push_back(r);
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic rs);
      if (sender_gaps && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_byte_value <= b;
      req_restart <= rs;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      parse_wav_byte(b, rs);
      parsed_bytes++;
   endtask

   task automatic send_id(input logic [31:0] id, input logic rs);
      for (int i = 0; i < 4; i++)
         send_byte(8'(id >> (24 - 8 * i)), rs && i == 0);
   endtask

   task automatic send_le32(input logic [31:0] v);
      for (int i = 0; i < 4; i++)
         send_byte(8'(v >> (8 * i)), 1'b0);
   endtask

   task automatic send_riff_header(input logic [31:0] file_size, input logic corrupt,
                                   input logic rs);
      logic [7:0] hdr [12];
      int         bad_pos;
      for (int i = 0; i < 4; i++) begin
         hdr[i] = 8'(wrp_pkg::ID_RIFF >> (24 - 8 * i));
         hdr[i + 4] = 8'(file_size >> (8 * i));
         hdr[i + 8] = 8'(WAVE_TAG >> (24 - 8 * i));
      end
      if (corrupt) begin
         bad_pos = $urandom_range(0, 7);
         if (bad_pos >= 4)
            bad_pos += 4;
         hdr[bad_pos] ^= 8'($urandom_range(1, 255));
      end
      for (int i = 0; i < 12; i++)
         send_byte(hdr[i], rs && i == 0);
   endtask

   // fill below zero means random body bytes
   task automatic send_chunk(input logic [31:0] id, input logic [31:0] size, input int fill);
      send_id(id, 1'b0);
      send_le32(size);
      for (int n = 0; n < size; n++)
         send_byte(fill < 0 ? 8'($urandom) : 8'(fill), 1'b0);
      if (size[0])
         send_byte(8'($urandom), 1'b0);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (wav_results_due.size() != 0)
         @(posedge clock);
   endtask

   task automatic random_file();
      int kind;
      if ($urandom_range(0, 14) == 0) begin
         // noise with stray restarts
         repeat ($urandom_range(1, 12))
            send_byte(8'($urandom), $urandom_range(0, 3) == 0);
         return;
      end
      send_riff_header($urandom, $urandom_range(0, 11) == 0, 1'b1);
      repeat ($urandom_range(1, 5)) begin
         kind = $urandom_range(0, 19);
         if (kind < 6) begin
            send_chunk(wrp_pkg::ID_FMT,
                       ($urandom_range(0, 2) == 0) ? $urandom_range(0, 24) : 16, -1);
         end else if (kind < 15) begin
            send_chunk(wrp_pkg::ID_DATA, $urandom_range(0, 40), -1);
         end else if (kind == 15) begin
            send_riff_header($urandom, $urandom_range(0, 5) == 0, 1'b0);
         end else if (kind == 16) begin
            send_id($urandom, 1'b0);
            repeat (3) send_byte(8'($urandom), 1'b0);
         end else if (kind == 17) begin
            repeat ($urandom_range(1, 8)) send_byte(8'($urandom), 1'b0);
         end else begin
            // oversized chunk cut short by the next file
            send_id($urandom_range(0, 1) ? wrp_pkg::ID_DATA : wrp_pkg::ID_FMT, 1'b0);
            send_le32($urandom | 32'h0100_0000);
            repeat ($urandom_range(0, 20)) send_byte(8'($urandom), 1'b0);
            return;
         end
      end
   endtask

   task automatic test_magic_errors();
      send_id(32'h5249_4658, 1'b1);
      send_byte(8'h00, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_id(wrp_pkg::ID_RIFF, 1'b1);
      send_le32(32'hFFFF_FFFF);
      send_id(32'h5741_5658, 1'b0);
      send_byte(8'h00, 1'b1);
      send_byte(8'h52, 1'b0);
      drain_results();
   endtask

   task automatic test_fmt_chunks();
      send_riff_header(32'h0, 1'b0, 1'b1);
      send_chunk(wrp_pkg::ID_FMT, 0, -1);
      send_chunk(wrp_pkg::ID_FMT, 3, 8'hFF);
      send_chunk(wrp_pkg::ID_FMT, 18, 8'hFF);
      send_chunk(wrp_pkg::ID_FMT, 16, 8'h00);
      drain_results();
   endtask

   task automatic test_data_chunks();
      send_riff_header($urandom, 1'b0, 1'b1);
      send_chunk(wrp_pkg::ID_FMT, 16, -1);
      send_chunk(wrp_pkg::ID_DATA, 0, -1);
      send_chunk(wrp_pkg::ID_DATA, 1, 8'hFF);
      send_chunk(wrp_pkg::ID_DATA, 2, 8'h00);
      send_riff_header($urandom, 1'b0, 1'b0);
      send_chunk(wrp_pkg::ID_DATA, 3, -1);
      send_chunk(JUNK_TAG, 0, -1);
      drain_results();
   endtask

   task automatic test_large_sizes();
      send_riff_header(32'hFFFF_FFFF, 1'b0, 1'b1);
      send_id(wrp_pkg::ID_DATA, 1'b0);
      send_le32(32'hFFFF_FFFF);
      repeat (3) send_byte(8'($urandom), 1'b0);
      send_riff_header(32'h0, 1'b0, 1'b1);
      send_id(wrp_pkg::ID_FMT, 1'b0);
      send_le32(32'hFFFF_FFFF);
      repeat (20) send_byte(8'($urandom), 1'b0);
      drain_results();
   endtask

   task automatic test_result_backpressure();
      sender_gaps = 1'b0;
      hold_receiver = 1'b1;
      send_riff_header($urandom, 1'b0, 1'b1);
      send_chunk(wrp_pkg::ID_DATA, 40, -1);
      drain_results();
   endtask

   task automatic test_random_files();
      int stop_at;
      stop_at = parsed_bytes + RANDOM_BYTES;
      while (parsed_bytes < stop_at) begin
         sender_gaps = $urandom_range(0, 3) != 0;
         receiver_stalls = $urandom_range(0, 3) != 0;
         random_file();
         if ($urandom_range(0, 7) == 0)
            drain_results();
      end
      drain_results();
   endtask

   task automatic test_steady_stream();
      sender_gaps = 1'b0;
      receiver_stalls = 1'b0;
      repeat (3) random_file();
      drain_results();
   endtask

   initial begin
      clear_parse_state();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_magic_errors();
      test_fmt_chunks();
      test_data_chunks();
      test_large_sizes();
      test_result_backpressure();
      test_random_files();
      test_steady_stream();
      repeat (8) @(posedge clock);
      if (mismatches == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   // receiver stalls, plus one long hold so the result buffer fills
   initial begin
      forever begin
         @(posedge clock);
         if (hold_receiver) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_stall <= 1'b0;
            hold_receiver = 1'b0;
         end else if (receiver_stalls && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 11)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin : check_results
      wav_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (wav_results_due.size() == 0) begin
            mismatches++;
            $display("%0t: result with none expected, expected none, actual status %0d",
                     $time, rsp_status);
         end else begin
            want = wav_results_due.pop_front();
            compare_field("status", want.status, rsp_status);
            compare_field("audio_byte", want.audio_byte, rsp_audio_byte);
            compare_field("last_audio", want.last_audio, rsp_last_audio);
            compare_field("format_ready", want.format_ready, rsp_format_ready);
            compare_field("format_tag", want.format_tag, rsp_format_tag);
            compare_field("channel_count", want.channel_count, rsp_channel_count);
            compare_field("sample_rate", want.sample_rate, rsp_sample_rate);
            compare_field("byte_rate", want.byte_rate, rsp_byte_rate);
            compare_field("block_align", want.block_align, rsp_block_align);
            compare_field("bits_per_sample", want.bits_per_sample, rsp_bits_per_sample);
            compare_field("data_size", want.data_size, rsp_data_size);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
         $display("RESULT: ERROR");
         $finish;
      end
   end

endmodule
